/* rtl/lpht_pkg.sv */
package lpht_pkg;

  // Fixed field widths
  localparam int CMD_W    = 1;
  localparam int LEN_W    = 4;
  localparam int HEAD_W   = 64;
  localparam int TAIL_W   = 8;
  localparam int STATUS_W = 3;
  localparam int SLOT_W   = 4;
  localparam int HASH_W   = 32;
  localparam int BYTE_W   = 8;

  // Largest key the field layout can carry (8 head bytes plus the tail byte)
  localparam int MAX_KEY_BYTES = 9;
  localparam int HEAD_BYTES    = HEAD_W / BYTE_W;

  // Stream packing
  localparam int IN_TDATA_W  = 80;  // len, head, tail = 76 bits, padded to bytes
  localparam int IN_TUSER_W  = CMD_W;
  localparam int OUT_TDATA_W = 8;   // slot, padded to a byte
  localparam int OUT_TUSER_W = STATUS_W;

  // Defaults for the top-level parameters
  localparam int TABLE_SLOTS_DEF = 13;
  localparam int KEY_BYTES_DEF   = 9;

  // Depth of the queue between front and back
  localparam int Q_DEPTH = 2;

  // Count of hash byte digits that the modulo step folds in
  localparam int MOD_STEPS = HASH_W / BYTE_W;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_SEARCH = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_INSERTED  = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_FOUND     = 3'd3,
    ST_NOT_FOUND = 3'd4,
    ST_EMPTY     = 3'd5
  } status_t;

  // Normalized key: bytes past the effective length are zero
  typedef struct packed {
    logic [LEN_W-1:0]  len;
    logic [TAIL_W-1:0] tail;
    logic [HEAD_W-1:0] head;
  } key_t;

  // One table slot as kept in the slot memory
  typedef struct packed {
    logic used;
    key_t key;
  } slot_t;

endpackage

/* rtl/linear_probe_hash_table.sv */
// Channel  Dir  Handshake             Payload
// in_      in   in_tvalid/in_tready   tuser: cmd; tdata: key_len, key_head, key_tail
// out_     out  out_tvalid/out_tready tuser: status; tdata: slot
//
// Front: accept, hash over each effective key byte, modulo one hash byte per
//   cycle, then push to the queue.
// Back: dispatch, then probe 1..TABLE_SLOTS slots in turn through the single
//   registered read port of the slot memory.
// An empty key skips hashing and probing.
// After reset a clearing pass zeroes every slot; in_tready is low meanwhile.
// A stalled out_ channel holds the back; the 2-deep queue lets the front
//   hash and hand over two more items, then hold a third, meanwhile.
module linear_probe_hash_table #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // [3:0] key_len, [67:4] key_head, [75:68] key_tail, [79:76] zero
  input  logic [lpht_pkg::IN_TDATA_W-1:0]  in_tdata,
  // [0] cmd
  input  logic [lpht_pkg::IN_TUSER_W-1:0]  in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [3:0] slot, [7:4] zero
  output logic [lpht_pkg::OUT_TDATA_W-1:0] out_tdata,
  // [2:0] status
  output logic [lpht_pkg::OUT_TUSER_W-1:0] out_tuser
);

  import lpht_pkg::*;

  localparam int RW = $clog2(TABLE_SLOTS);
  localparam int QW = 2 + RW + $bits(key_t);

  logic                q_valid;
  logic                q_ready;
  logic [QW-1:0]       q_wdata;
  logic                q_out_valid;
  logic                q_pop;
  logic [QW-1:0]       q_rdata;
  logic                clearing;
  status_t             status;
  logic [SLOT_W-1:0]   slot;

  // Front: key normalization, hash and home slot
  lpht_front #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .KEY_BYTES   (KEY_BYTES),
    .QW          (QW)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .clearing    (clearing),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_cmd      (in_tuser[0]),
    .in_key_len  (in_tdata[LEN_W-1:0]),
    .in_key_head (in_tdata[LEN_W +: HEAD_W]),
    .in_key_tail (in_tdata[LEN_W+HEAD_W +: TAIL_W]),
    .q_valid     (q_valid),
    .q_ready     (q_ready),
    .q_data      (q_wdata)
  );

  lpht_queue #(
    .WIDTH (QW),
    .DEPTH (Q_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (q_valid),
    .push_ready (q_ready),
    .push_data  (q_wdata),
    .pop_valid  (q_out_valid),
    .pop        (q_pop),
    .pop_data   (q_rdata)
  );

  // Back: linear probe over the slot memory, insert or search
  lpht_back #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .QW          (QW)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .clearing   (clearing),
    .q_valid    (q_out_valid),
    .q_pop      (q_pop),
    .q_data     (q_rdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_status (status),
    .out_slot   (slot)
  );

  assign out_tuser = status;
  assign out_tdata = {(OUT_TDATA_W - SLOT_W)'(0), slot};

endmodule

/* rtl/lpht_queue.sv */
module lpht_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] q_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;
  logic             push;

  assign push_ready = (count_r != CW'(DEPTH));
  assign pop_valid  = (count_r != '0);
  assign push       = push_valid && push_ready;
  assign pop_data   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push && !pop) begin
        count_r <= count_r + 1'b1;
      end else if (!push && pop) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (count_r != '0))
    else $error("queue popped while empty");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count missed a push");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("queue count beyond depth");

endmodule

/* rtl/lpht_front.sv */
module lpht_front #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = lpht_pkg::KEY_BYTES_DEF,
  parameter int QW          = 8
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        clearing,
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic                        in_cmd,
  input  logic [lpht_pkg::LEN_W-1:0]  in_key_len,
  input  logic [lpht_pkg::HEAD_W-1:0] in_key_head,
  input  logic [lpht_pkg::TAIL_W-1:0] in_key_tail,
  output logic                        q_valid,
  input  logic                        q_ready,
  output logic [QW-1:0]               q_data
);

  import lpht_pkg::*;

  localparam int RW = $clog2(TABLE_SLOTS);
  localparam int MW = RW + BYTE_W;
  localparam logic [MW-1:0] TM = MW'(TABLE_SLOTS);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_HASH = 4'b0010,
    F_MOD  = 4'b0100,
    F_PUSH = 4'b1000
  } fstate_t;

  fstate_t state_r, state_nxt;

  logic [BYTE_W-1:0]        in_byte [MAX_KEY_BYTES];
  logic [LEN_W-1:0]         len_sat;
  logic [LEN_W-1:0]         eff;
  logic                     alive;
  key_t                     key_norm;
  key_t                     key_r;
  logic [TAIL_W+HEAD_W-1:0] sh_r;
  logic [HASH_W-1:0]        h_r;
  logic [RW-1:0]            r_r;
  logic [LEN_W-1:0]         cnt_r;
  logic                     cmd_r;
  logic                     empty_r;
  logic [MW-1:0]            rem_t;
  logic                     accept;

  // Saturate length, cut key at the first zero byte, zero the rest
  always_comb begin
    for (int i = 0; i < HEAD_BYTES; i++) begin
      in_byte[i] = in_key_head[BYTE_W*i +: BYTE_W];
    end
    in_byte[HEAD_BYTES] = in_key_tail;
    len_sat = (in_key_len > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES) : in_key_len;
    alive = 1'b1;
    eff   = '0;
    for (int i = 0; i < MAX_KEY_BYTES; i++) begin
      if (alive && (LEN_W'(i) < len_sat) && (in_byte[i] != '0)) begin
        eff = LEN_W'(i + 1);
      end else begin
        alive = 1'b0;
      end
    end
    key_norm.len = eff;
    for (int i = 0; i < HEAD_BYTES; i++) begin
      key_norm.head[BYTE_W*i +: BYTE_W] = (LEN_W'(i) < eff) ? in_byte[i] : '0;
    end
    key_norm.tail = (LEN_W'(HEAD_BYTES) < eff) ? in_byte[HEAD_BYTES] : '0;
  end

  // One byte digit of the hash folded into the remainder
  always_comb begin
    rem_t = {r_r, h_r[HASH_W-1 -: BYTE_W]};
    for (int k = BYTE_W - 1; k >= 0; k--) begin
      if (rem_t >= (TM << k)) begin
        rem_t = rem_t - (TM << k);
      end
    end
  end

  assign in_tready = (state_r == F_IDLE) && !clearing;
  assign accept    = in_tvalid && in_tready;
  assign q_valid   = (state_r == F_PUSH);
  assign q_data    = {cmd_r, empty_r, r_r, key_r};

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = (eff == '0) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_r + 1'b1 == key_r.len) begin
          state_nxt = F_MOD;
        end
      end
      F_MOD: begin
        if (cnt_r == LEN_W'(MOD_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (q_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          key_r   <= key_norm;
          sh_r    <= {key_norm.tail, key_norm.head};
          cmd_r   <= in_cmd;
          empty_r <= (eff == '0);
          h_r     <= '0;
          r_r     <= '0;
          cnt_r   <= '0;
        end
      end
      F_HASH: begin
        // h = 31*h + b, wrapping at 32 bits
        h_r  <= (h_r << 5) - h_r + HASH_W'(sh_r[BYTE_W-1:0]);
        sh_r <= sh_r >> BYTE_W;
        cnt_r <= (cnt_r + 1'b1 == key_r.len) ? '0 : cnt_r + 1'b1;
      end
      F_MOD: begin
        r_r   <= rem_t[RW-1:0];
        h_r   <= h_r << BYTE_W;
        cnt_r <= cnt_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

endmodule

/* rtl/lpht_back.sv */
module lpht_back #(
  parameter int TABLE_SLOTS = lpht_pkg::TABLE_SLOTS_DEF,
  parameter int QW          = 8
) (
  input  logic                          clk,
  input  logic                          rst_n,
  output logic                          clearing,
  input  logic                          q_valid,
  output logic                          q_pop,
  input  logic [QW-1:0]                 q_data,
  output logic                          out_tvalid,
  input  logic                          out_tready,
  output lpht_pkg::status_t             out_status,
  output logic [lpht_pkg::SLOT_W-1:0]   out_slot
);

  import lpht_pkg::*;

  localparam int RW = $clog2(TABLE_SLOTS);

  typedef enum logic [1:0] {
    B_IDLE  = 2'b01,
    B_PROBE = 2'b10
  } bstate_t;

  bstate_t state_r;

  slot_t          mem [TABLE_SLOTS];
  slot_t          rd_q_r;
  logic           rd_en;
  logic [RW-1:0]  rd_addr;
  logic           mem_we;
  logic [RW-1:0]  mem_wa;
  slot_t          mem_wd;

  logic           clearing_r;
  logic [RW-1:0]  clr_cnt_r;

  logic           cmd_r;
  key_t           key_r;
  logic [RW-1:0]  s_r;
  logic [RW-1:0]  n_r;
  logic [RW-1:0]  s_wrap;

  logic           q_cmd;
  logic           q_empty;
  logic [RW-1:0]  q_home;
  key_t           q_key;

  logic           out_free;
  logic           hit_free;
  logic           hit_eq;
  logic           last;
  logic           done;
  logic           emit;
  status_t        emit_status;
  logic [RW-1:0]  emit_slot;

  logic           out_tvalid_r;
  status_t        out_status_r;
  logic [SLOT_W-1:0] out_slot_r;

  assign {q_cmd, q_empty, q_home, q_key} = q_data;

  assign clearing = clearing_r;
  assign out_free = !out_tvalid_r || out_tready;
  assign s_wrap   = (s_r == RW'(TABLE_SLOTS - 1)) ? '0 : s_r + 1'b1;

  assign hit_free = !rd_q_r.used;
  assign hit_eq   = rd_q_r.used && (rd_q_r.key == key_r);
  assign last     = (n_r == RW'(TABLE_SLOTS - 1));
  assign done     = hit_free || hit_eq || last;

  assign q_pop = (state_r == B_IDLE) && q_valid && !clearing_r && (!q_empty || out_free);

  always_comb begin
    emit        = 1'b0;
    emit_status = ST_EMPTY;
    emit_slot   = '0;
    rd_en       = 1'b0;
    rd_addr     = q_home;
    mem_we      = clearing_r;
    mem_wa      = clr_cnt_r;
    mem_wd      = '0;
    unique case (state_r)
      B_IDLE: begin
        if (q_pop) begin
          if (q_empty) begin
            emit = 1'b1;
          end else begin
            rd_en = 1'b1;
          end
        end
      end
      B_PROBE: begin
        if (!done) begin
          rd_en   = 1'b1;
          rd_addr = s_wrap;
        end else if (out_free) begin
          emit = 1'b1;
          if (hit_free) begin
            if (cmd_r == CMD_INSERT) begin
              emit_status = ST_INSERTED;
              emit_slot   = s_r;
              mem_we      = 1'b1;
              mem_wa      = s_r;
              mem_wd      = '{used: 1'b1, key: key_r};
            end else begin
              emit_status = ST_NOT_FOUND;
            end
          end else if (hit_eq) begin
            if (cmd_r == CMD_INSERT) begin
              emit_status = ST_DUPLICATE;
            end else begin
              emit_status = ST_FOUND;
              emit_slot   = s_r;
            end
          end else begin
            emit_status = (cmd_r == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Slot memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_wa] <= mem_wd;
    end
    if (rd_en) begin
      rd_q_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= B_IDLE;
      clearing_r   <= 1'b1;
      clr_cnt_r    <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      if (clearing_r) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
        if (clr_cnt_r == RW'(TABLE_SLOTS - 1)) begin
          clearing_r <= 1'b0;
        end
      end
      if (emit) begin
        out_tvalid_r <= 1'b1;
      end else if (out_tready) begin
        out_tvalid_r <= 1'b0;
      end
      unique case (state_r)
        B_IDLE: begin
          if (q_pop && !q_empty) begin
            state_r <= B_PROBE;
          end
        end
        B_PROBE: begin
          if (emit) begin
            state_r <= B_IDLE;
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_status_r <= emit_status;
      out_slot_r   <= SLOT_W'(emit_slot);
    end
    if (state_r == B_IDLE) begin
      cmd_r <= q_cmd;
      key_r <= q_key;
      s_r   <= q_home;
      n_r   <= '0;
    end else if (!done) begin
      s_r <= s_wrap;
      n_r <= n_r + 1'b1;
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_status = out_status_r;
  assign out_slot   = out_slot_r;

  a_write_gated: assert property (@(posedge clk) disable iff (!rst_n)
    mem_we |-> (clearing_r ||
                (state_r == B_PROBE && !rd_q_r.used && cmd_r == CMD_INSERT)))
    else $error("slot memory written outside insert or clear");

  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_r |-> !q_pop)
    else $error("item taken during clearing pass");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid_r && !out_tready) |-> !emit)
    else $error("result overwrote a pending result");

endmodule
